// File: hw/rtl/mhpq_pkg.sv
// Shared constants and types for the max-heap priority queue.
// No dependencies; used by every module of the block.
`default_nettype none

package mhpq_pkg;

    // Key width and output packing
    localparam int KEY_W        = 32;
    localparam int CNT_OUT_W    = 5;
    localparam int STATUS_W     = 2;
    localparam int OUT_TDATA_W  = 40;
    localparam int CAPACITY_DEF = 31;

    // Operation codes (tuser of the input side)
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/mhpq_store.sv
// Heap key store: one write port, one read port, registered read data.
// Depends on mhpq_pkg. Entry 0 is never used; positions run 1..CAPACITY.
`default_nettype none

module mhpq_store #(
    parameter int  CAPACITY = mhpq_pkg::CAPACITY_DEF,
    localparam int AW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [mhpq_pkg::KEY_W-1:0] i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [mhpq_pkg::KEY_W-1:0] o_rdata
);

    logic [mhpq_pkg::KEY_W-1:0] r_mem [0:CAPACITY];
    logic [mhpq_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/mhpq_seq.sv
// Heap sequencer: entry count, sift-up / sift-down walk over the key store,
// one shared signed comparator. Depends on mhpq_pkg; drives mhpq_store.
`default_nettype none

module mhpq_seq #(
    parameter int  CAPACITY = mhpq_pkg::CAPACITY_DEF,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_op,
    input  wire logic [mhpq_pkg::KEY_W-1:0] i_key,
    output logic                            o_idle,
    output logic                            o_done,
    output mhpq_pkg::t_result               o_result,
    output logic      [CW-1:0]              o_count,
    // store port
    output logic                            o_we,
    output logic      [CW-1:0]              o_waddr,
    output logic      [mhpq_pkg::KEY_W-1:0] o_wdata,
    output logic      [CW-1:0]              o_raddr,
    input  wire logic [mhpq_pkg::KEY_W-1:0] i_rdata
);

    localparam int PW = CW + 1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_UP       = 9'b000000010,
        S_UP_FIN   = 9'b000000100,
        S_POP_TOP  = 9'b000001000,
        S_POP_LAST = 9'b000010000,
        S_DN_LEFT  = 9'b000100000,
        S_DN_RIGHT = 9'b001000000,
        S_DN_STEP  = 9'b010000000,
        S_REPLY    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_pos, n_pos;
    logic [CW-1:0]                  r_child, n_child;
    logic [mhpq_pkg::KEY_W-1:0]     r_key, n_key;       // pushed or moved key
    logic [mhpq_pkg::KEY_W-1:0]     r_ckey, n_ckey;     // larger child key
    logic [mhpq_pkg::KEY_W-1:0]     r_top, n_top;
    logic [mhpq_pkg::STATUS_W-1:0]  r_status, n_status;

    // shared comparator: a > b, signed
    logic [mhpq_pkg::KEY_W-1:0] w_cmp_a, w_cmp_b;
    logic                       w_gt;

    logic [PW-1:0] w_cnt_ext, w_left, w_right, w_cleft;
    logic [CW-1:0] w_cnt_inc;

    assign w_cmp_a   = (r_state == S_UP) ? r_key : r_ckey;
    assign w_cmp_b   = (r_state == S_DN_STEP) ? r_key : i_rdata;
    assign w_gt      = $signed(w_cmp_a) > $signed(w_cmp_b);

    assign w_cnt_ext = {1'b0, r_count};
    assign w_left    = {r_pos, 1'b0};
    assign w_right   = w_left + PW'(1);
    assign w_cleft   = {r_child, 1'b0};
    assign w_cnt_inc = r_count + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_child  = r_child;
        n_key    = r_key;
        n_ckey   = r_ckey;
        n_top    = r_top;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_pos;
        o_wdata  = r_key;
        o_raddr  = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_top    = '0;
                    n_status = mhpq_pkg::ST_OK;
                    if (i_op == mhpq_pkg::OP_PUSH) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = S_REPLY;
                        end else begin
                            n_count = w_cnt_inc;
                            n_pos   = w_cnt_inc;
                            n_key   = i_key;
                            o_raddr = w_cnt_inc >> 1;
                            n_state = (r_count == '0) ? S_UP_FIN : S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = S_REPLY;
                        end else begin
                            n_count = r_count - CW'(1);
                            o_raddr = CW'(1);
                            n_state = S_POP_TOP;
                        end
                    end
                end
            end
            // parent of r_pos sits in i_rdata
            S_UP: begin
                o_we = 1'b1;
                if (w_gt) begin
                    o_wdata = i_rdata;
                    n_pos   = r_pos >> 1;
                    o_raddr = r_pos >> 2;
                    if ((r_pos >> 1) == CW'(1)) begin
                        n_state = S_UP_FIN;
                    end
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_UP_FIN: begin
                o_we    = 1'b1;
                n_state = S_REPLY;
            end
            S_POP_TOP: begin
                n_top   = i_rdata;
                o_raddr = w_cnt_inc;            // old last position
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_key   = i_rdata;
                n_pos   = CW'(1);
                o_raddr = CW'(2);
                if (r_count == '0) begin
                    n_state = S_REPLY;
                end else if (r_count == CW'(1)) begin
                    // root has no child: a single placing write, as at the
                    // end of a sift-up
                    n_state = S_UP_FIN;
                end else begin
                    n_state = S_DN_LEFT;
                end
            end
            S_DN_LEFT: begin
                n_ckey  = i_rdata;
                n_child = w_left[CW-1:0];
                o_raddr = w_right[CW-1:0];
                n_state = (w_right <= w_cnt_ext) ? S_DN_RIGHT : S_DN_STEP;
            end
            // ties go to the right child
            S_DN_RIGHT: begin
                if (!w_gt) begin
                    n_ckey  = i_rdata;
                    n_child = r_child + CW'(1);
                end
                n_state = S_DN_STEP;
            end
            S_DN_STEP: begin
                o_we = 1'b1;
                if (w_gt) begin
                    o_wdata = r_ckey;
                    n_pos   = r_child;
                    o_raddr = w_cleft[CW-1:0];
                    n_state = (w_cleft <= w_cnt_ext) ? S_DN_LEFT : S_UP_FIN;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_child  <= n_child;
        r_key    <= n_key;
        r_ckey   <= n_ckey;
        r_top    <= n_top;
        r_status <= n_status;
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_done          = (r_state == S_REPLY);
    assign o_result.status = r_status;
    assign o_result.key    = r_top;
    assign o_count         = r_count;

endmodule

`default_nettype wire

// File: hw/rtl/max_heap_priority_queue_top.sv
// Top level of the max-heap priority queue: stream ports, output register.
// Depends on mhpq_pkg, mhpq_store and mhpq_seq.
//
// Usage
//   Input channel s_axis_*: tuser[0] is the operation (0 push, 1 pop),
//   tdata[31:0] the signed key to push (ignored on pop).
//   Output channel m_axis_*: tuser[1:0] the status (ok, full, empty),
//   tdata[31:0] the key removed by a pop (0 otherwise), tdata[36:32] the
//   low five bits of the key count after the item.
//   Every input item gives exactly one output item, in order.
// Flow
//   One item is worked on at a time; s_axis_tready is low from acceptance
//   until its result is loaded into the output register. The walk runs over the
//   key store, which has one write port and one read port, with L heap levels compared:
//     refused push / pop:  no walk
//     push:                one store read per level
//     pop:                 left read, right read, compare per level, then
//                          the placing write
//   For 31 keys L is at most 4.
// Reset
//   i_rst_n low (synchronous) empties the heap and the output register.
//   Store contents are not cleared; only data from live positions is ever used.
// Stall
//   A result waits in the output register while m_axis_tready is low; no
//   new item is taken until that register is free or being emptied.
`default_nettype none

module max_heap_priority_queue_top #(
    parameter int  CAPACITY = mhpq_pkg::CAPACITY_DEF,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mhpq_pkg::KEY_W-1:0]          s_axis_tdata,  // [31:0] key_in
    input  wire logic                                s_axis_tuser,  // [0] operation
    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [mhpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] key_out,
                                                                    // [36:32] count_after
    output logic      [mhpq_pkg::STATUS_W-1:0]       m_axis_tuser   // [1:0] status
);

    localparam int PAD_W = mhpq_pkg::OUT_TDATA_W - mhpq_pkg::KEY_W - mhpq_pkg::CNT_OUT_W;

    logic                       w_idle, w_done, w_start;
    mhpq_pkg::t_result          w_result;
    logic [CW-1:0]              w_count;
    logic                       w_we;
    logic [CW-1:0]              w_waddr, w_raddr;
    logic [mhpq_pkg::KEY_W-1:0] w_wdata, w_rdata;
    logic [CW+mhpq_pkg::CNT_OUT_W-1:0] w_count_ext;

    // output register
    logic                             r_out_valid;
    logic [mhpq_pkg::STATUS_W-1:0]    r_out_status;
    logic [mhpq_pkg::KEY_W-1:0]       r_out_key;
    logic [mhpq_pkg::CNT_OUT_W-1:0]   r_out_count;

    assign s_axis_tready = w_idle && (!r_out_valid || m_axis_tready);
    assign w_start       = s_axis_tvalid && s_axis_tready;

    mhpq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_op     (s_axis_tuser),
        .i_key    (s_axis_tdata),
        .o_idle   (w_idle),
        .o_done   (w_done),
        .o_result (w_result),
        .o_count  (w_count),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    mhpq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // count_after carries the low five bits of the count
    assign w_count_ext = {{mhpq_pkg::CNT_OUT_W{1'b0}}, w_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_status <= w_result.status;
            r_out_key    <= w_result.key;
            r_out_count  <= w_count_ext[mhpq_pkg::CNT_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out_key};
    assign m_axis_tuser  = r_out_status;

    // A finished result never lands on an occupied output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_out_valid || m_axis_tready)
        else $error("result overwrote a waiting output item");

    // Only one item in flight: acceptance drops ready on the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    // A refused push only happens on a full heap.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_result.status == mhpq_pkg::ST_FULL) |-> w_count == CW'(CAPACITY))
        else $error("full reported below capacity");

    // An empty pop leaves an empty heap and a zero key.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_result.status == mhpq_pkg::ST_EMPTY) |->
            (w_count == '0 && w_result.key == '0))
        else $error("empty pop with keys held or non-zero key");

endmodule

`default_nettype wire
